// ----- src/upe_pkg.sv -----
// shared types, constants and helpers of the utf-8 percent encoder
`default_nettype none

package upe_pkg;

  // field widths
  localparam int unsigned CHAR_W = 21;
  localparam int unsigned OUT_W  = 7;

  // pass-through range
  localparam logic [CHAR_W-1:0] PASS_LOW  = CHAR_W'(33);
  localparam logic [CHAR_W-1:0] PASS_HIGH = CHAR_W'(127);

  // utf-8 length boundaries
  localparam logic [CHAR_W-1:0] LIM_ONE   = CHAR_W'(32'h80);
  localparam logic [CHAR_W-1:0] LIM_TWO   = CHAR_W'(32'h800);
  localparam logic [CHAR_W-1:0] LIM_THREE = CHAR_W'(32'h10000);

  // utf-8 lead and continuation marks
  localparam logic [7:0] LEAD_TWO   = 8'hc0;
  localparam logic [7:0] LEAD_THREE = 8'he0;
  localparam logic [7:0] LEAD_FOUR  = 8'hf0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // escape character
  localparam logic [OUT_W-1:0] PCT_CHAR = OUT_W'(8'h25);

  // one decoded input item
  typedef struct packed {
    logic             pass;       // value goes out as one character
    logic [OUT_W-1:0] pass_char;
    logic [3:0][7:0]  bytes;      // bytes[0] is sent first
    logic [1:0]       last_byte;  // index of the final byte
    logic             last;       // final character of the text
  } item_t;

  // lower-case hex digit of one nibble
  function automatic logic [OUT_W-1:0] hex_digit(input logic [3:0] nib);
    logic [OUT_W-1:0] d;
    if (nib < 4'd10) begin
      d = OUT_W'(8'h30) + OUT_W'(nib);
    end else begin
      d = OUT_W'(8'h57) + OUT_W'(nib);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- src/upe_decode.sv -----
// splits one character value into a pass-through character or escape bytes
`default_nettype none

module upe_decode (
  input  wire logic                       input_mode,
  input  wire logic [upe_pkg::CHAR_W-1:0] char_value,
  input  wire logic                       last_of_text,
  output upe_pkg::item_t                  item
);
  import upe_pkg::*;

  logic [CHAR_W-1:0] val;

  // byte mode keeps the low byte only
  assign val = input_mode ? {{(CHAR_W-8){1'b0}}, char_value[7:0]} : char_value;

  // utf-8 split and pass-through check
  always_comb begin
    item           = '0;
    item.pass      = (val >= PASS_LOW) && (val <= PASS_HIGH);
    item.pass_char = val[OUT_W-1:0];
    item.last      = last_of_text;
    if (input_mode || (val < LIM_ONE)) begin
      item.bytes[0]  = val[7:0];
      item.last_byte = 2'd0;
    end else if (val < LIM_TWO) begin
      item.bytes[0]  = LEAD_TWO | {3'd0, val[10:6]};
      item.bytes[1]  = CONT_MARK | {2'd0, val[5:0]};
      item.last_byte = 2'd1;
    end else if (val < LIM_THREE) begin
      item.bytes[0]  = LEAD_THREE | {4'd0, val[15:12]};
      item.bytes[1]  = CONT_MARK | {2'd0, val[11:6]};
      item.bytes[2]  = CONT_MARK | {2'd0, val[5:0]};
      item.last_byte = 2'd2;
    end else begin
      item.bytes[0]  = LEAD_FOUR | {5'd0, val[20:18]};
      item.bytes[1]  = CONT_MARK | {2'd0, val[17:12]};
      item.bytes[2]  = CONT_MARK | {2'd0, val[11:6]};
      item.bytes[3]  = CONT_MARK | {2'd0, val[5:0]};
      item.last_byte = 2'd3;
    end
  end

endmodule

`default_nettype wire

// ----- src/upe_serial.sv -----
// item register, character stepping and output register
`default_nettype none

module upe_serial (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire upe_pkg::item_t            item,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [upe_pkg::OUT_W-1:0]      out_char,
  output logic                           last_of_run,
  output logic                           end_of_text
);
  import upe_pkg::*;

  typedef enum logic [1:0] {
    PH_PCT,
    PH_HI,
    PH_LO
  } phase_t;

  logic             cur_valid;
  item_t            cur;
  logic [1:0]       byte_idx;
  phase_t           phase;
  logic             adv;
  logic             emit;
  logic             cur_last;
  logic [7:0]       cur_byte;
  logic [OUT_W-1:0] char_next;

  // output register free to take a character
  assign adv      = !out_valid || out_ready;
  assign emit     = cur_valid && adv;
  assign cur_last = cur.pass || ((byte_idx == cur.last_byte) && (phase == PH_LO));
  assign in_ready = !cur_valid || (emit && cur_last);
  assign cur_byte = cur.bytes[byte_idx];

  // character selection
  always_comb begin
    char_next = PCT_CHAR;
    if (cur.pass) begin
      char_next = cur.pass_char;
    end else begin
      unique case (phase)
        PH_PCT:  char_next = PCT_CHAR;
        PH_HI:   char_next = hex_digit(cur_byte[7:4]);
        PH_LO:   char_next = hex_digit(cur_byte[3:0]);
        default: char_next = PCT_CHAR;
      endcase
    end
  end

  // item register and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      byte_idx  <= 2'd0;
      phase     <= PH_PCT;
    end else if (in_valid && in_ready) begin
      cur_valid <= 1'b1;
      byte_idx  <= 2'd0;
      phase     <= PH_PCT;
    end else if (emit && cur_last) begin
      cur_valid <= 1'b0;
    end else if (emit) begin
      unique case (phase)
        PH_PCT:  phase <= PH_HI;
        PH_HI:   phase <= PH_LO;
        PH_LO: begin
          phase    <= PH_PCT;
          byte_idx <= byte_idx + 2'd1;
        end
        default: phase <= PH_PCT;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= item;
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= char_next;
      last_of_run <= cur_last;
      end_of_text <= cur_last && cur.last;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8_percent_encoder.sv -----
// top level of the utf-8 percent encoder
`default_nettype none

// Turns character values into 7-bit ASCII text, one character per output
// beat. Values 33 to 127 go out unchanged; any other value is escaped as
// '%' plus two lower-case hex digits per byte, with 1 to 4 UTF-8 bytes in
// code-point mode (input_mode 0) or the low byte of the value in byte mode
// (input_mode 1). An item gives 1, 3, 6, 9 or 12 output beats; the output
// port moves one character per cycle unless out_ready stalls it. The next
// item is taken in the cycle its predecessor's final character enters the
// output register, so unstalled single-character items flow one per cycle.
// Beats pass the item register, then the output register. The user writes
// input_mode through cfg_write/cfg_data while idle, unchecked by the block.

module utf8_percent_encoder (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic                       cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [upe_pkg::CHAR_W-1:0] char_value,
  input  wire logic                       last_of_text,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [upe_pkg::OUT_W-1:0]       out_char,
  output logic                            last_of_run,
  output logic                            end_of_text
);
  import upe_pkg::*;

  logic  input_mode;
  item_t item;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode <= 1'b0;
    end else if (cfg_write) begin
      input_mode <= cfg_data;
    end
  end

  // decode of the incoming beat
  upe_decode u_decode (
    .input_mode   (input_mode),
    .char_value   (char_value),
    .last_of_text (last_of_text),
    .item         (item)
  );

  // character stepping and output
  upe_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .item        (item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .last_of_run (last_of_run),
    .end_of_text (end_of_text)
  );

endmodule

`default_nettype wire

// ----- src/upe_checker.sv -----
// port-level checks of the utf-8 percent encoder and their bind
`default_nettype none

module upe_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [upe_pkg::OUT_W-1:0]  out_char,
  input wire logic                       last_of_run,
  input wire logic                       end_of_text
);
  import upe_pkg::*;

  // output beats stall with their payload held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char)
      && $stable(last_of_run) && $stable(end_of_text))
    else $error("output beat changed while stalled");

  // end of text only on the final character of a run
  a_eot_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_text |-> last_of_run)
    else $error("end_of_text without last_of_run");

  // every character sent has a code of 33 or more
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_char >= OUT_W'(33))
    else $error("character outside the safe range");

  // nothing is sent straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // an item accepted with nothing queued then reaches the output
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid ##1 !rst |-> ##1 out_valid)
    else $error("accepted beat did not reach the output");

endmodule

bind utf8_percent_encoder upe_checker u_upe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_char    (out_char),
  .last_of_run (last_of_run),
  .end_of_text (end_of_text)
);

`default_nettype wire
